/* rtl/tkh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_pkg: shared types and constants of the top-K min-heap tracker
// Heap geometry, command codes, controller states and the control/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tkh_pkg;

    localparam int MAX_K = 16;
    localparam int VAL_W = 32;
    localparam int K_W   = 5;
    localparam int IDX_W = $clog2(MAX_K);
    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam int CHD_W = IDX_W + 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_EMIT,
        S_BUILD_RD,
        S_BUILD_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_EMPTY_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_CHILD,
        RD_BUILD,
        RD_DUMP
    } t_rd_sel;

    typedef struct packed {
        logic    append;
        logic    load_in;
        logic    build_init;
        logic    build_ld;
        logic    build_dec;
        logic    sift_fin;
        logic    sift_step;
        logic    dump_init;
        logic    emit_ins;
        logic    emit_dump;
        logic    emit_empty;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_dump;
        logic below_k;
        logic fill_last;
        logic gt_root;
        logic cnt_zero;
        logic child_out;
        logic sift_stop;
        logic i_zero;
        logic dump_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/tkh_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_in_if: command channel of the top-K tracker
// Valid/ready channel carrying one insert or dump command.
// ----------------------------------------------------------------------------
interface tkh_in_if;
    import tkh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

/* rtl/tkh_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_out_if: result channel of the top-K tracker
// Valid/ready channel carrying one insert result or one dumped entry.
// ----------------------------------------------------------------------------
interface tkh_out_if;
    import tkh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [IDX_W-1:0]        entry_index;
    logic [CNT_W-1:0]        stored_count;
    logic                    heap_full;
    logic                    entry_valid;
    logic                    last;

    modport source (
        output valid, output result_value, output entry_index, output stored_count,
        output heap_full, output entry_valid, output last, input ready
    );
    modport sink (
        input valid, input result_value, input entry_index, input stored_count,
        input heap_full, input entry_valid, input last, output ready
    );
endinterface

/* rtl/tkh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_ram: generic RAM, one write port, two registered read ports
// Read data shows the contents before a write in the same cycle.
// ----------------------------------------------------------------------------
module tkh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

/* rtl/tkh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_ctrl: sequencer of the top-K tracker
// Steps append, heap build, sift-down and dump through the datapath.
// ----------------------------------------------------------------------------
module tkh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tkh_pkg::t_dp_stat i_stat,
    output tkh_pkg::t_dp_cmd  o_cmd
);
    import tkh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_dump) begin
                        n_state = i_stat.cnt_zero ? S_EMPTY_EMIT : S_DUMP_RD;
                    end else if (i_stat.below_k) begin
                        n_state = i_stat.fill_last ? S_BUILD_RD : S_INS_EMIT;
                    end else begin
                        n_state = i_stat.gt_root ? S_SIFT_RD : S_INS_EMIT;
                    end
                end
            end
            S_INS_EMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_BUILD_RD: n_state = S_BUILD_LD;
            S_BUILD_LD: n_state = S_SIFT_RD;
            S_SIFT_RD: begin
                if (i_stat.child_out) begin
                    n_state = i_stat.i_zero ? S_INS_EMIT : S_BUILD_RD;
                end else begin
                    n_state = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP: begin
                if (i_stat.sift_stop) begin
                    n_state = i_stat.i_zero ? S_INS_EMIT : S_BUILD_RD;
                end else begin
                    n_state = S_SIFT_RD;
                end
            end
            S_DUMP_RD: n_state = S_DUMP_EMIT;
            S_DUMP_EMIT: begin
                if (i_stat.out_free) n_state = i_stat.dump_last ? S_IDLE : S_DUMP_RD;
            end
            S_EMPTY_EMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_CHILD;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_stat.in_dump) begin
                        o_cmd.dump_init = !i_stat.cnt_zero;
                    end else if (i_stat.below_k) begin
                        o_cmd.append     = 1'b1;
                        o_cmd.build_init = i_stat.fill_last;
                    end else begin
                        o_cmd.load_in = i_stat.gt_root;
                    end
                end
            end
            S_INS_EMIT:   o_cmd.emit_ins = i_stat.out_free;
            S_BUILD_RD:   o_cmd.rd_sel = RD_BUILD;
            S_BUILD_LD:   o_cmd.build_ld = 1'b1;
            S_SIFT_RD: begin
                if (i_stat.child_out) begin
                    o_cmd.sift_fin  = 1'b1;
                    o_cmd.build_dec = !i_stat.i_zero;
                end
            end
            S_SIFT_CMP: begin
                o_cmd.sift_step = 1'b1;
                o_cmd.build_dec = i_stat.sift_stop && !i_stat.i_zero;
            end
            S_DUMP_RD:    o_cmd.rd_sel = RD_DUMP;
            S_DUMP_EMIT: begin
                o_cmd.rd_sel    = RD_DUMP;
                o_cmd.emit_dump = i_stat.out_free;
            end
            S_EMPTY_EMIT: o_cmd.emit_empty = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_sift_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIFT_RD) |-> !i_stat.below_k)
        else $error("sift-down started on a heap that is not full");

    a_dump_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP_EMIT) |-> !i_stat.cnt_zero)
        else $error("entry dump running on an empty heap");
`endif
endmodule

/* rtl/tkh_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkh_dp: datapath of the top-K tracker
// Heap RAM, count and k registers, sift-down compare and the result register.
// ----------------------------------------------------------------------------
module tkh_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tkh_pkg::K_W-1:0]        i_cfg_wr_data,
    input  logic                           i_in_command,
    input  logic signed [tkh_pkg::VAL_W-1:0] i_in_value,
    input  tkh_pkg::t_dp_cmd               i_cmd,
    output tkh_pkg::t_dp_stat              o_stat,
    tkh_out_if.source                      o_out
);
    import tkh_pkg::*;

    logic [CNT_W-1:0]        r_k;
    logic [CNT_W-1:0]        n_k;
    logic [CNT_W-1:0]        r_count;
    logic signed [VAL_W-1:0] r_root;
    logic signed [VAL_W-1:0] r_v;
    logic [IDX_W-1:0]        r_pos;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_idx;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic [IDX_W-1:0]        r_out_index;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_out_full;
    logic                    r_out_entry;
    logic                    r_out_last;

    logic                    w_we;
    logic [IDX_W-1:0]        w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic [IDX_W-1:0]        w_raddr_a;
    logic signed [VAL_W-1:0] w_rdata_a;
    logic signed [VAL_W-1:0] w_rdata_b;

    logic [CHD_W-1:0]        w_child;
    logic [CHD_W-1:0]        w_right;
    logic                    w_right_ok;
    logic                    w_pick_right;
    logic signed [VAL_W-1:0] w_cv;
    logic [IDX_W-1:0]        w_cidx;
    logic                    w_stop;
    logic                    w_dump_last;
    logic                    w_out_free;

    // Child addresses of the current sift position
    assign w_child      = {r_pos, 1'b1};
    assign w_right      = w_child + CHD_W'(1);
    assign w_right_ok   = w_child < (r_k - CNT_W'(1));
    assign w_pick_right = w_right_ok && (w_rdata_b < w_rdata_a);
    assign w_cv         = w_pick_right ? w_rdata_b : w_rdata_a;
    assign w_cidx       = w_pick_right ? w_right[IDX_W-1:0] : w_child[IDX_W-1:0];
    assign w_stop       = r_v < w_cv;
    assign w_dump_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign w_out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        o_stat.in_dump   = i_in_command == CMD_DUMP;
        o_stat.below_k   = r_count < r_k;
        o_stat.fill_last = (r_count + CNT_W'(1)) == r_k;
        o_stat.gt_root   = r_root < i_in_value;
        o_stat.cnt_zero  = r_count == '0;
        o_stat.child_out = w_child >= r_k;
        o_stat.sift_stop = w_stop;
        o_stat.i_zero    = r_i == '0;
        o_stat.dump_last = w_dump_last;
        o_stat.out_free  = w_out_free;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_v;
        if (i_cmd.append) begin
            w_we    = 1'b1;
            w_waddr = r_count[IDX_W-1:0];
            w_wdata = i_in_value;
        end else if (i_cmd.sift_fin) begin
            w_we = 1'b1;
        end else if (i_cmd.sift_step) begin
            w_we    = 1'b1;
            w_wdata = w_stop ? r_v : w_cv;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_CHILD: w_raddr_a = w_child[IDX_W-1:0];
            RD_BUILD: w_raddr_a = r_i;
            RD_DUMP:  w_raddr_a = r_idx;
            default:  w_raddr_a = w_child[IDX_W-1:0];
        endcase
    end

    tkh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_K)
    ) u_heap (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_right[IDX_W-1:0]),
        .o_rdata_b (w_rdata_b)
    );

    // Clamp k into 1..MAX_K on write
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_k = CNT_W'(1);
        end else if (i_cfg_wr_data > K_W'(MAX_K)) begin
            n_k = CNT_W'(MAX_K);
        end else begin
            n_k = CNT_W'(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= CNT_W'(MAX_K);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en && r_count == '0) r_k <= n_k;
            if (i_cmd.append) r_count <= r_count + CNT_W'(1);
            if (i_cmd.emit_ins || i_cmd.emit_dump || i_cmd.emit_empty) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && w_waddr == '0) r_root <= w_wdata;
        if (i_cmd.load_in) begin
            r_v   <= i_in_value;
            r_pos <= '0;
            r_i   <= '0;
        end
        if (i_cmd.build_init) r_i <= IDX_W'((r_k - CNT_W'(1)) >> 1);
        if (i_cmd.build_ld) begin
            r_v   <= w_rdata_a;
            r_pos <= r_i;
        end
        if (i_cmd.build_dec) r_i <= r_i - IDX_W'(1);
        if (i_cmd.sift_step && !w_stop) r_pos <= w_cidx;
        if (i_cmd.dump_init) r_idx <= '0;
        if (i_cmd.emit_dump) r_idx <= r_idx + IDX_W'(1);

        if (i_cmd.emit_ins) begin
            r_out_value <= (r_count == '0) ? '0 : r_root;
            r_out_index <= '0;
            r_out_count <= r_count;
            r_out_full  <= r_count == r_k;
            r_out_entry <= 1'b1;
            r_out_last  <= 1'b1;
        end else if (i_cmd.emit_dump) begin
            r_out_value <= w_rdata_a;
            r_out_index <= r_idx;
            r_out_count <= r_count;
            r_out_full  <= r_count == r_k;
            r_out_entry <= 1'b1;
            r_out_last  <= w_dump_last;
        end else if (i_cmd.emit_empty) begin
            r_out_value <= '0;
            r_out_index <= '0;
            r_out_count <= '0;
            r_out_full  <= 1'b0;
            r_out_entry <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.entry_index  = r_out_index;
    assign o_out.stored_count = r_out_count;
    assign o_out.heap_full    = r_out_full;
    assign o_out.entry_valid  = r_out_entry;
    assign o_out.last         = r_out_last;

`ifndef ASSERT_OFF
    a_count_le_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_k)
        else $error("held count above k");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0) && (r_k <= CNT_W'(MAX_K)))
        else $error("k outside 1..MAX_K");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CNT_W'(w_waddr) < r_k))
        else $error("heap write beyond k");
`endif
endmodule

/* rtl/top_k_min_heap_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_min_heap_tracker: keep the K largest signed values of a stream
// Min-heap of up to MAX_K entries in a RAM; insert, bottom-up build on the
// K-th value, replace-root with sift-down, and dump in heap array order.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        command, value
//  o_out     out  valid/ready        result_value, entry_index, stored_count,
//                                    heap_full, entry_valid, last
//  i_cfg     in   i_cfg_wr_en only   i_cfg_wr_data (k_in_use)
//
//  Steps: an insert that only appends or is dropped emits its result and
//  returns to idle; a root replacement walks the new root down one level at
//  a time until it stops or ends on a leaf; the fill that completes the heap
//  runs one sift-down per node from (k-1)/2 down to the root. A dump reads
//  and emits each held entry in turn. Each sift level is set by the registered
//  RAM read: read both children, then compare/write.
//  Reset (synchronous, active low) clears the held count, sets k to 16 and
//  idles the sequencer; heap contents are not cleared, no clearing pass.
//  A stalled o_out holds the result register; the next command is taken
//  once the sequencer is back in idle, even while a result still waits.
//
module top_k_min_heap_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tkh_pkg::K_W-1:0]    i_cfg_wr_data,
    tkh_in_if.sink                     i_in,
    tkh_out_if.source                  o_out
);
    import tkh_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    // Sequencer: owns the input handshake, drives datapath commands
    tkh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: heap storage, compares and the output transaction register
    tkh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_command  (i_in.command),
        .i_in_value    (i_in.value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out         (o_out)
    );

    assign i_in.ready = w_in_ready;

`ifndef ASSERT_OFF
    // One command at a time: after a transaction the sequencer is busy
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready) |=> !w_in_ready)
        else $error("input taken while the previous command is still running");
`endif
endmodule

/* dv/tb_top_k_min_heap_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_min_heap_tracker: self-checking bench for the top-K min-heap tracker
// Drives insert and dump commands through the valid/ready input channel, keeps
// a behavioral copy of the heap, and checks every result transaction against
// it. Both channel sides insert random gaps, and the result side holds off for
// a long stretch once so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top_k_min_heap_tracker;
    import tkh_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
        logic [CNT_W-1:0]        count;
        logic                    full;
        logic                    valid;
        logic                    last;
    } t_heap_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [K_W-1:0]    i_cfg_wr_data;

    tkh_in_if  in_if ();
    tkh_out_if out_if ();

    top_k_min_heap_tracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Heap predictor: a plain array heap with the same tie rules as the block
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] heap_model [MAX_K];
    int unsigned             held_n;
    logic [K_W-1:0]          keep_reg;
    t_heap_report            heap_reports [$];

    int unsigned mismatches;
    int unsigned rx_hold_cycles;
    bit          tx_gaps_on;
    bit          rx_gaps_on;

    // Append one predicted transaction at the tail of the queue.
    function automatic void add_report(input t_heap_report rep);
        heap_reports = {heap_reports, rep};
    endfunction

    // Out-of-range register values clamp: 0 keeps one value, above MAX_K keeps MAX_K.
    function automatic int unsigned keep_limit();
        if (keep_reg == '0) begin
            return 1;
        end
        if (keep_reg > MAX_K) begin
            return MAX_K;
        end
        return keep_reg;
    endfunction

    // Walk the value at pos down; take the right child only when strictly
    // smaller, and move down past a child equal to the moving value.
    function automatic void heap_sift_down(int unsigned pos, int unsigned n);
        logic signed [VAL_W-1:0] moving;
        int unsigned             child;
        moving = heap_model[pos];
        child  = pos * 2 + 1;
        while (child < n) begin
            if (child + 1 < n && heap_model[child + 1] < heap_model[child]) begin
                child++;
            end
            if (moving < heap_model[child]) begin
                break;
            end
            heap_model[pos] = heap_model[child];
            pos   = child;
            child = child * 2 + 1;
        end
        heap_model[pos] = moving;
    endfunction

    // Advance the heap by one accepted command and queue the results it causes.
    function automatic void heap_apply(logic cmd, logic signed [VAL_W-1:0] val);
        int unsigned  k;
        t_heap_report rep;
        k = keep_limit();
        if (cmd == CMD_INSERT) begin
            if (held_n < k) begin
                heap_model[held_n] = val;
                held_n++;
                // The k-th value completes the array: build bottom-up.
                if (held_n == k) begin
                    for (int i = (k - 1) / 2; i >= 0; i--) begin
                        heap_sift_down(i, k);
                    end
                end
            end else if (heap_model[0] < val) begin
                heap_model[0] = val;
                heap_sift_down(0, k);
            end
            rep.value = (held_n != 0) ? heap_model[0] : '0;
            rep.index = '0;
            rep.count = CNT_W'(held_n);
            rep.full  = (held_n == k);
            rep.valid = 1'b1;
            rep.last  = 1'b1;
            add_report(rep);
        end else if (held_n == 0) begin
            // Empty dump: a single all-zero transaction flagged last.
            rep       = '0;
            rep.last  = 1'b1;
            add_report(rep);
        end else begin
            for (int unsigned i = 0; i < held_n; i++) begin
                rep.value = heap_model[i];
                rep.index = IDX_W'(i);
                rep.count = CNT_W'(held_n);
                rep.full  = (held_n == k);
                rep.valid = 1'b1;
                rep.last  = (i + 1 == held_n);
                add_report(rep);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random ready gaps, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned gap;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = rx_gaps_on ? $urandom_range(0, 10) : 0;
            if (rx_hold_cycles != 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap != 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            // Hold ready until a transaction completes or a hold-off is asked for.
            do @(posedge i_clk); while (!out_if.valid && rx_hold_cycles == 0);
        end
    end

    task automatic flag_result(input string tag, input t_heap_report want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected val=%0d idx=%0d cnt=%0d full=%0b ev=%0b last=%0b",
                     $time, tag, want.value, want.index, want.count, want.full,
                     want.valid, want.last);
            $display("%0t %s:      got val=%0d idx=%0d cnt=%0d full=%0b ev=%0b last=%0b",
                     $time, tag, out_if.result_value, out_if.entry_index,
                     out_if.stored_count, out_if.heap_full, out_if.entry_valid,
                     out_if.last);
        end
    endtask

    // Compare every completed result transaction with the oldest prediction.
    t_heap_report want_rep;
    t_heap_report got_rep;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_rep.value = out_if.result_value;
            got_rep.index = out_if.entry_index;
            got_rep.count = out_if.stored_count;
            got_rep.full  = out_if.heap_full;
            got_rep.valid = out_if.entry_valid;
            got_rep.last  = out_if.last;
            if (heap_reports.size() == 0) begin
                flag_result("unexpected result", '0);
            end else begin
                want_rep = heap_reports.pop_front();
                if (got_rep !== want_rep) begin
                    flag_result("result mismatch", want_rep);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Offer one command after a random gap and hold it until the transaction
    // completes; valid stays high afterwards so back-to-back commands need no
    // second assignment in the same step.
    task automatic send_command(input logic cmd, input logic signed [VAL_W-1:0] val);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.command <= cmd;
        in_if.value   <= val;
        do @(posedge i_clk); while (!in_if.ready);
        heap_apply(cmd, val);
    endtask

    // Drop valid and wait until every predicted result has been seen.
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (heap_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The block takes the write only while nothing is held; mirror that here.
    task automatic write_keep_count(input logic [K_W-1:0] kval);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= kval;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        if (held_n == 0) begin
            keep_reg = kval;
        end
        @(posedge i_clk);
    endtask

    // Register extremes before the first insert, and a dump of the empty heap.
    task automatic test_config_and_empty_dump();
        logic [K_W-1:0] k_final;
        write_keep_count('0);
        write_keep_count(5'd31);
        write_keep_count(5'd1);
        // Mostly keep the clamped maximum for the deepest sift paths.
        k_final = ($urandom_range(0, 3) == 0) ? K_W'($urandom_range(0, 31)) : 5'd31;
        write_keep_count(k_final);
        send_command(CMD_DUMP, 32'h1234_5678);
        wait_for_results();
    endtask

    // Extremes, ties, partial dump, fill that triggers the build, then the
    // drop and replace paths against the settled root.
    task automatic test_directed_heap();
        logic signed [VAL_W-1:0] root;
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_INSERT, 32'h7FFF_FFFF);
        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'sd5);
        send_command(CMD_INSERT, 32'sd5);
        send_command(CMD_INSERT, 32'sd5);
        send_command(CMD_DUMP, 32'hFFFF_FFFF);
        // Descending fill forces moves during the bottom-up build.
        for (int i = 0; i < 9 && held_n < keep_limit(); i++) begin
            send_command(CMD_INSERT, 32'sd1000 - 32'sd7 * i);
        end
        send_command(CMD_DUMP, 32'h0000_0000);
        root = heap_model[0];
        send_command(CMD_INSERT, root);
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_INSERT, 32'h7FFF_FFFF);
        send_command(CMD_INSERT, heap_model[0] + 32'sd1);
        send_command(CMD_DUMP, 32'h5A5A_A5A5);
        wait_for_results();
    endtask

    // Writes while values are held must leave k untouched.
    task automatic test_config_while_held();
        write_keep_count('0);
        write_keep_count(5'd7);
        send_command(CMD_INSERT, 32'h7FFF_FFFE);
        send_command(CMD_DUMP, 32'h0);
        wait_for_results();
    endtask

    // Hold the result side off while commands keep coming, so the block
    // stalls its input; then pause the sender until everything has drained.
    task automatic test_backpressure();
        logic signed [VAL_W-1:0] val;
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 20; i++) begin
            val = heap_model[0];
            val = val + $urandom_range(0, 4);
            send_command((i % 7 == 6) ? CMD_DUMP : CMD_INSERT, val);
        end
        wait_for_results();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_stream();
        logic signed [VAL_W-1:0] val;
        logic                    cmd;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Re-draw the idling mix now and then, including gap-free stretches.
            if (n % 60 == 0) begin
                tx_gaps_on = ($urandom_range(0, 2) != 0);
                rx_gaps_on = ($urandom_range(0, 2) != 0);
            end
            cmd = ($urandom_range(0, 9) == 0) ? CMD_DUMP : CMD_INSERT;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: val = $urandom;
                4, 5: begin
                    val = $urandom_range(0, 40);
                    val = val - 32'sd20;
                end
                6, 7, 8: begin
                    // Land near the root to hit ties and real replacements.
                    val = heap_model[0];
                    val = val + $urandom_range(0, 5) - 2;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h7FFF_FFFF;
                        2:       val = 32'h0000_0000;
                        default: val = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
            send_command(cmd, val);
            if ($urandom_range(0, 49) == 0) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        in_if.valid    = 1'b0;
        in_if.command  = CMD_INSERT;
        in_if.value    = '0;
        mismatches     = 0;
        rx_hold_cycles = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        held_n         = 0;
        keep_reg       = 5'd16;
        for (int i = 0; i < MAX_K; i++) begin
            heap_model[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_config_and_empty_dump();
        test_directed_heap();
        test_config_while_held();
        test_backpressure();
        test_random_stream();

        if (mismatches == 0) begin
            $display("** top_k_min_heap_tracker: PASSED **");
        end else begin
            $display("** top_k_min_heap_tracker: FAILED **");
        end
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("** top_k_min_heap_tracker: FAILED **");
        $finish;
    end

endmodule
